@@ hw/rtl/m4rm_pkg.sv @@
// Package for the 4x4 matrix row multiply unit: shared types and constants.
`default_nettype none
package m4rm_pkg;

  localparam int unsigned ELEMS = 4;
  localparam int unsigned ROW_W = 2;
  localparam int unsigned ELEM_W = 32;
  localparam int unsigned PROD_W = 2 * ELEM_W;
  localparam int unsigned PAIR_W = PROD_W + 1;
  localparam int unsigned SUM_W = PROD_W + 2;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_MUL = 1'b1;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic [ROW_W-1:0] row_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0] sum_t;

  localparam elem_t ELEM_MAX = 32'sh7FFF_FFFF;
  localparam elem_t ELEM_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

@@ hw/rtl/matrix4_row_multiply_unit.sv @@
// Top level of the 4x4 matrix row multiply unit in signed fixed point.
//
//  channel | ports                                             | direction
//  --------+---------------------------------------------------+----------
//  in      | in_valid in_ready in_func in_row_index in_elem_0..3 | to block
//  out     | out_valid out_ready out_row out_elem_0..3 out_saturated | from block
//
// out_valid rises after a multiply item is accepted, through five register
// stages: input register, 16 parallel 32x32 multipliers, pair adds, column
// adds, then shift and saturate into the output register. One item enters
// per cycle while in_ready is high. A load item writes its row of the right-hand
// store at acceptance and yields no result. Reset clears the store and all valid
// bits. A stalled output holds each stage that has no free slot behind it.
`default_nettype none
module matrix4_row_multiply_unit
  import m4rm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_func,
  input  wire row_t        in_row_index,
  input  wire elem_t       in_elem_0,
  input  wire elem_t       in_elem_1,
  input  wire elem_t       in_elem_2,
  input  wire elem_t       in_elem_3,
  output logic             out_valid,
  input  wire logic        out_ready,
  output row_t             out_row,
  output elem_t            out_elem_0,
  output elem_t            out_elem_1,
  output elem_t            out_elem_2,
  output elem_t            out_elem_3,
  output logic             out_saturated
);

  elem_t in_elem [ELEMS];
  elem_t rhs_r [ELEMS*ELEMS];

  logic  v1_r, v2_r, v3_r, v4_r, v5_r;
  logic  en1, en2, en3, en4, en5;
  logic  in_acc;

  row_t  row1_r, row2_r, row3_r, row4_r, row5_r;
  elem_t lhs_r [ELEMS];
  prod_t prod_r [ELEMS][ELEMS];
  pair_t pair_r [ELEMS][2];
  sum_t  sum_r [ELEMS];
  elem_t res_r [ELEMS];
  logic  sat_r;

  elem_t res_nxt [ELEMS];
  logic  sat_nxt;
  sum_t  shifted [ELEMS];

  assign in_elem[0] = in_elem_0;
  assign in_elem[1] = in_elem_1;
  assign in_elem[2] = in_elem_2;
  assign in_elem[3] = in_elem_3;

  // advance a stage when it is empty or the one behind it advances
  assign en5 = !v5_r || out_ready;
  assign en4 = !v4_r || en5;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_ready = en1;
  assign in_acc = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ELEMS*ELEMS; i++) begin
        rhs_r[i] <= '0;
      end
    end else if (in_acc && in_func == FUNC_LOAD) begin
      for (int c = 0; c < ELEMS; c++) begin
        rhs_r[{in_row_index, 2'(c)}] <= in_elem[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid && in_func == FUNC_MUL;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
      if (en5) v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      row1_r <= in_row_index;
      for (int c = 0; c < ELEMS; c++) begin
        lhs_r[c] <= in_elem[c];
      end
    end
    if (en2) begin
      row2_r <= row1_r;
      for (int k = 0; k < ELEMS; k++) begin
        for (int c = 0; c < ELEMS; c++) begin
          prod_r[k][c] <= prod_t'(lhs_r[k]) * prod_t'(rhs_r[{2'(k), 2'(c)}]);
        end
      end
    end
    if (en3) begin
      row3_r <= row2_r;
      for (int c = 0; c < ELEMS; c++) begin
        pair_r[c][0] <= PAIR_W'(prod_r[0][c]) + PAIR_W'(prod_r[1][c]);
        pair_r[c][1] <= PAIR_W'(prod_r[2][c]) + PAIR_W'(prod_r[3][c]);
      end
    end
    if (en4) begin
      row4_r <= row3_r;
      for (int c = 0; c < ELEMS; c++) begin
        sum_r[c] <= SUM_W'(pair_r[c][0]) + SUM_W'(pair_r[c][1]);
      end
    end
    if (en5) begin
      row5_r <= row4_r;
      sat_r <= sat_nxt;
      for (int c = 0; c < ELEMS; c++) begin
        res_r[c] <= res_nxt[c];
      end
    end
  end

  // floor by arithmetic shift, then clamp to 32 bits
  always_comb begin
    sat_nxt = 1'b0;
    for (int c = 0; c < ELEMS; c++) begin
      shifted[c] = sum_r[c] >>> FRAC_BITS;
      if (!shifted[c][SUM_W-1] && shifted[c][SUM_W-2:ELEM_W-1] != '0) begin
        res_nxt[c] = ELEM_MAX;
        sat_nxt = 1'b1;
      end else if (shifted[c][SUM_W-1] && shifted[c][SUM_W-2:ELEM_W-1] != '1) begin
        res_nxt[c] = ELEM_MIN;
        sat_nxt = 1'b1;
      end else begin
        res_nxt[c] = shifted[c][ELEM_W-1:0];
      end
    end
  end

  assign out_valid = v5_r;
  assign out_row = row5_r;
  assign out_elem_0 = res_r[0];
  assign out_elem_1 = res_r[1];
  assign out_elem_2 = res_r[2];
  assign out_elem_3 = res_r[3];
  assign out_saturated = sat_r;

  a_load_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_func == FUNC_LOAD |=> !v1_r)
    else $error("load item entered the pipeline");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v1_r && v2_r && v3_r && v4_r && v5_r && !out_ready)
    else $error("input stalled with a free stage");

  a_sat_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |->
      out_elem_0 == ELEM_MAX || out_elem_0 == ELEM_MIN ||
      out_elem_1 == ELEM_MAX || out_elem_1 == ELEM_MIN ||
      out_elem_2 == ELEM_MAX || out_elem_2 == ELEM_MIN ||
      out_elem_3 == ELEM_MAX || out_elem_3 == ELEM_MIN)
    else $error("saturated flag without a clamped element");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule
`default_nettype wire
